// ===== hw/rtl/laplacian_sobel_sharpness_defines.svh =====
// Assertion macros shared by the sharpness measure RTL
`ifndef LAPLACIAN_SOBEL_SHARPNESS_DEFINES_SVH
`define LAPLACIAN_SOBEL_SHARPNESS_DEFINES_SVH

// clocked property, disabled while reset is high
`define LSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked property, also checked during reset
`define LSS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/lss_pkg.sv =====
// Types and constants of the sharpness measure
`timescale 1ns / 1ps
`default_nettype none
package lss_pkg;
   localparam int PIX_W  = 12;
   localparam int GRAD_W = 16;
   localparam int L2_W   = 28;
   localparam int S1_W   = 39;
   localparam int S2_W   = 52;
   localparam int G_W    = 53;
   localparam int N_W    = 25;
   localparam int VAR_W  = 36;
   localparam int SOB_W  = 37;
   localparam int DIV_W  = 61;
   localparam int CFG_W  = 13;
   localparam int BRD_W  = 7;
   localparam int IDX_W  = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 104;

   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] REG_BORDER_WIDTH = 2'd2;

   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd1920;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd1080;
   localparam logic [BRD_W-1:0] RST_BORDER_WIDTH = 7'd16;

   typedef struct packed {
      logic [S1_W-1:0] s1;
      logic [S2_W-1:0] s2;
      logic [G_W-1:0]  g;
      logic [N_W-1:0]  n;
   } totals_type;
endpackage
`default_nettype wire

// ===== hw/rtl/laplacian_sobel_sharpness.sv =====
// Top level of the Laplacian variance and Sobel energy sharpness measure
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata: luma_pixel
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: variance, energy, count
//  csr      in         csr_wr_en              csr_index, csr_wdata
//
// Each pixel passes accept, line-store read and window, multiply and accumulate in turn.
// The last pixel of a frame starts three divisions in turn on the shared divider; once the
// result is registered, new pixels are taken again.
// Synchronous reset; the line stores are not cleared and need no clearing pass.
// A waiting result does not stall pixels until the next frame's result needs the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "laplacian_sobel_sharpness_defines.svh"
module laplacian_sobel_sharpness #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lss_pkg::REQ_DATA_W-1:0] req_tdata,  // [11:0] luma_pixel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [35:0] lap_variance, [72:36] sobel_energy, [97:73] measured_pixels
   output logic [lss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [lss_pkg::IDX_W-1:0]      csr_index,
   input  logic [lss_pkg::CFG_W-1:0]      csr_wdata
);
   import lss_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int MW    = (WW > HW) ? WW : HW;
   localparam int CMP_W = ((MW > 9) ? MW : 9) + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   function automatic logic signed [GRAD_W-1:0] ext(input logic [PIX_W-1:0] v);
      return signed'(GRAD_W'(v));
   endfunction

   logic [CFG_W-1:0]  width_ff;
   logic [CFG_W-1:0]  height_ff;
   logic [BRD_W-1:0]  border_ff;
   logic [1:0]        state_ff;
   logic [XW-1:0]     col_ff;
   logic [YW-1:0]     line_ff;
   logic [PIX_W-1:0]  win_ff [6];
   logic [PIX_W-1:0]  pix_ff;
   logic [XW-1:0]     addr_ff;
   logic              meas_ff;
   logic              end_ff;
   logic signed [GRAD_W-1:0] lap_ff;
   logic signed [GRAD_W-1:0] gx_ff;
   logic signed [GRAD_W-1:0] gy_ff;
   logic [L2_W-1:0]   l2_ff;
   logic [L2_W-1:0]   gx2_ff;
   logic [L2_W-1:0]   gy2_ff;
   totals_type        acc_ff;

   logic [CFG_W:0]    w_cl;
   logic [CFG_W:0]    h_cl;
   logic [CMP_W-1:0]  w_eff;
   logic [CMP_W-1:0]  h_eff;
   logic [CMP_W-1:0]  b_eff;
   logic [CMP_W-1:0]  lim;
   logic [CMP_W-1:0]  x_c;
   logic [CMP_W-1:0]  y_c;
   logic [CMP_W-1:0]  cx;
   logic [CMP_W-1:0]  cy;
   logic              too_small;
   logic              meas_in;
   logic              end_line;
   logic              end_frame;
   logic              accept;
   logic [2*PIX_W-1:0] rd_data;
   logic [PIX_W-1:0]  top;
   logic [PIX_W-1:0]  mid;
   logic signed [GRAD_W-1:0] lap_in;
   logic signed [GRAD_W-1:0] gx_in;
   logic signed [GRAD_W-1:0] gy_in;
   logic signed [2*GRAD_W-1:0] l2_p;
   logic signed [2*GRAD_W-1:0] gx2_p;
   logic signed [2*GRAD_W-1:0] gy2_p;
   totals_type        acc_in;
   logic              fin_start;
   logic              fin_busy;
   logic [VAR_W-1:0]  lap_variance;
   logic [SOB_W-1:0]  sobel_energy;
   logic [N_W-1:0]    measured_pixels;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_FRAME_WIDTH;
         height_ff <= RST_FRAME_HEIGHT;
         border_ff <= RST_BORDER_WIDTH;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            REG_BORDER_WIDTH: border_ff <= csr_wdata[BRD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_cl = {1'b0, width_ff};
      if (width_ff == '0) begin
         w_cl = (CFG_W + 1)'(1);
      end else if (w_cl > (CFG_W + 1)'(MAX_WIDTH)) begin
         w_cl = (CFG_W + 1)'(MAX_WIDTH);
      end
      h_cl = {1'b0, height_ff};
      if (height_ff == '0) begin
         h_cl = (CFG_W + 1)'(1);
      end else if (h_cl > (CFG_W + 1)'(MAX_HEIGHT)) begin
         h_cl = (CFG_W + 1)'(MAX_HEIGHT);
      end
      w_eff = CMP_W'(w_cl);
      h_eff = CMP_W'(h_cl);
      b_eff = (border_ff == '0) ? CMP_W'(1) : CMP_W'(border_ff);
      lim   = (b_eff << 1) + CMP_W'(2);
      too_small = (w_eff <= lim) || (h_eff <= lim);
      x_c   = CMP_W'(col_ff);
      y_c   = CMP_W'(line_ff);
      cx    = x_c - CMP_W'(1);
      cy    = y_c - CMP_W'(1);
      meas_in = !too_small && (col_ff != '0) && (line_ff != '0) &&
                (cx >= b_eff) && ((cx + b_eff) < w_eff) &&
                (cy >= b_eff) && ((cy + b_eff) < h_eff);
      end_line  = (x_c + CMP_W'(1)) >= w_eff;
      end_frame = end_line && ((y_c + CMP_W'(1)) >= h_eff);
   end

   assign req_tready = (state_ff == ST_IDLE) && !fin_busy;
   assign accept     = req_tvalid && req_tready;

   lss_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (XW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (state_ff == ST_CALC),
      .wr_addr (addr_ff),
      .wr_data ({mid, pix_ff})
   );

   always_comb begin
      top    = rd_data[2*PIX_W-1:PIX_W];
      mid    = rd_data[PIX_W-1:0];
      lap_in = ext(win_ff[1]) + ext(mid) + ext(win_ff[3]) + ext(win_ff[5])
               - (ext(win_ff[4]) <<< 2);
      gx_in  = (ext(top) + (ext(mid) <<< 1) + ext(pix_ff))
               - (ext(win_ff[0]) + (ext(win_ff[1]) <<< 1) + ext(win_ff[2]));
      gy_in  = (ext(win_ff[2]) + (ext(win_ff[5]) <<< 1) + ext(pix_ff))
               - (ext(win_ff[0]) + (ext(win_ff[3]) <<< 1) + ext(top));
      l2_p   = lap_ff * lap_ff;
      gx2_p  = gx_ff * gx_ff;
      gy2_p  = gy_ff * gy_ff;
      acc_in = acc_ff;
      if (meas_ff) begin
         acc_in.s1 = acc_ff.s1 + {{(S1_W - GRAD_W){lap_ff[GRAD_W-1]}}, lap_ff};
         acc_in.s2 = acc_ff.s2 + S2_W'(l2_ff);
         acc_in.g  = acc_ff.g + G_W'(gx2_ff) + G_W'(gy2_ff);
         acc_in.n  = acc_ff.n + 1'b1;
      end
      fin_start = (state_ff == ST_ACC) && end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         line_ff  <= '0;
         acc_ff   <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pix_ff   <= req_tdata[PIX_W-1:0];
                  addr_ff  <= col_ff;
                  meas_ff  <= meas_in;
                  end_ff   <= end_frame;
                  col_ff   <= end_line ? '0 : col_ff + 1'b1;
                  if (end_line) begin
                     line_ff <= end_frame ? '0 : line_ff + 1'b1;
                  end
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               lap_ff    <= lap_in;
               gx_ff     <= gx_in;
               gy_ff     <= gy_in;
               win_ff[0] <= win_ff[3];
               win_ff[1] <= win_ff[4];
               win_ff[2] <= win_ff[5];
               win_ff[3] <= top;
               win_ff[4] <= mid;
               win_ff[5] <= pix_ff;
               state_ff  <= ST_MUL;
            end
            ST_MUL: begin
               l2_ff    <= l2_p[L2_W-1:0];
               gx2_ff   <= gx2_p[L2_W-1:0];
               gy2_ff   <= gy2_p[L2_W-1:0];
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff   <= end_ff ? '0 : acc_in;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   lss_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .start           (fin_start),
      .totals          (acc_in),
      .busy            (fin_busy),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .lap_variance    (lap_variance),
      .sobel_energy    (sobel_energy),
      .measured_pixels (measured_pixels)
   );

   assign rsp_tdata = {(RSP_DATA_W - VAR_W - SOB_W - N_W)'(0),
                       measured_pixels, sobel_energy, lap_variance};

   `LSS_ASSERT(a_launch_idle, fin_start |-> !fin_busy, "frame end while divider busy")
   `LSS_ASSERT(a_accept_calc, accept |=> (state_ff == ST_CALC), "accept did not start calc")
   `LSS_ASSERT(a_store_write, (state_ff == ST_CALC) |-> $past(accept), "store write, no pixel")
endmodule
`default_nettype wire

// ===== hw/rtl/lss_line_store.sv =====
// Two line stores held as one synchronous memory, one read and one write port
`timescale 1ns / 1ps
`default_nettype none
module lss_line_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [2*lss_pkg::PIX_W-1:0]   rd_data,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [2*lss_pkg::PIX_W-1:0]   wr_data
);
   import lss_pkg::*;

   logic [2*PIX_W-1:0] mem [DEPTH];
   logic [2*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/lss_divider.sv =====
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module lss_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lss_pkg::DIV_W-1:0] dividend,
   input  logic [lss_pkg::N_W-1:0]   divisor,
   output logic                      done,
   output logic [lss_pkg::DIV_W-1:0] quotient
);
   import lss_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [N_W-1:0]   rem_ff;
   logic [N_W-1:0]   dsr_ff;
   logic [N_W:0]     trial;
   logic [N_W:0]     diff;
   logic             fits;
   logic [N_W-1:0]   rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      diff   = trial - {1'b0, dsr_ff};
      rem_in = fits ? diff[N_W-1:0] : trial[N_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W - 1);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            rem_ff <= rem_in;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/lss_finish.sv =====
// End-of-frame sequencer: divisions, variance and result register
`timescale 1ns / 1ps
`default_nettype none
module lss_finish (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  lss_pkg::totals_type       totals,
   output logic                      busy,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lss_pkg::VAR_W-1:0] lap_variance,
   output logic [lss_pkg::SOB_W-1:0] sobel_energy,
   output logic [lss_pkg::N_W-1:0]   measured_pixels
);
   import lss_pkg::*;

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_LOAD = 3'd1;
   localparam logic [2:0] F_MEAN = 3'd2;
   localparam logic [2:0] F_FL   = 3'd3;
   localparam logic [2:0] F_SOB  = 3'd4;
   localparam logic [2:0] F_SQ   = 3'd5;
   localparam logic [2:0] F_VAR  = 3'd6;
   localparam logic [2:0] F_WAIT = 3'd7;

   logic [2:0]       state_ff;
   totals_type       tot_ff;
   logic [DIV_W-1:0] mag_ff;
   logic [DIV_W-1:0] fl_ff;
   logic [SOB_W-1:0] sob_ff;
   logic [63:0]      sq_ff;
   logic             big_ff;
   logic [VAR_W-1:0] var_ff;
   logic             rsp_valid_ff;
   logic [VAR_W-1:0] rsp_var_ff;
   logic [SOB_W-1:0] rsp_sob_ff;
   logic [N_W-1:0]   rsp_n_ff;

   logic             div_start;
   logic             div_done;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_quotient;
   logic [S1_W-1:0]  s1_mag;
   logic [63:0]      fl_ext;
   logic [63:0]      var_diff;
   logic [VAR_W-1:0] var_in;

   always_comb begin
      s1_mag = tot_ff.s1[S1_W-1] ? (~tot_ff.s1 + 1'b1) : tot_ff.s1;
      case (state_ff)
         F_LOAD:  div_dividend = DIV_W'({s1_mag, 4'b0});
         F_MEAN:  div_dividend = DIV_W'({tot_ff.s2, 8'b0});
         default: div_dividend = DIV_W'({tot_ff.g, 8'b0});
      endcase
      div_start = (state_ff == F_LOAD) ||
                  (div_done && ((state_ff == F_MEAN) || (state_ff == F_FL)));
      fl_ext   = 64'(fl_ff);
      var_diff = fl_ext - sq_ff;
      if (big_ff || !(fl_ext > sq_ff)) begin
         var_in = '0;
      end else if (|var_diff[63:VAR_W]) begin
         var_in = '1;
      end else begin
         var_in = var_diff[VAR_W-1:0];
      end
   end

   lss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (tot_ff.n),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == F_WAIT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            F_IDLE: begin
               if (start) begin
                  tot_ff <= totals;
                  if (totals.n == '0) begin
                     var_ff   <= '0;
                     sob_ff   <= '0;
                     state_ff <= F_WAIT;
                  end else begin
                     state_ff <= F_LOAD;
                  end
               end
            end
            F_LOAD: state_ff <= F_MEAN;
            F_MEAN: begin
               if (div_done) begin
                  mag_ff   <= div_quotient;
                  state_ff <= F_FL;
               end
            end
            F_FL: begin
               if (div_done) begin
                  fl_ff    <= div_quotient;
                  state_ff <= F_SOB;
               end
            end
            F_SOB: begin
               if (div_done) begin
                  sob_ff   <= (|div_quotient[DIV_W-1:SOB_W]) ? '1 :
                              div_quotient[SOB_W-1:0];
                  state_ff <= F_SQ;
               end
            end
            F_SQ: begin
               sq_ff    <= mag_ff[31:0] * mag_ff[31:0];
               big_ff   <= |mag_ff[DIV_W-1:32];
               state_ff <= F_VAR;
            end
            F_VAR: begin
               var_ff   <= var_in;
               state_ff <= F_WAIT;
            end
            F_WAIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_var_ff   <= var_ff;
                  rsp_sob_ff   <= sob_ff;
                  rsp_n_ff     <= tot_ff.n;
                  state_ff     <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign busy            = state_ff != F_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign lap_variance    = rsp_var_ff;
   assign sobel_energy    = rsp_sob_ff;
   assign measured_pixels = rsp_n_ff;
endmodule
`default_nettype wire

// ===== sim/tb_laplacian_sobel_sharpness.sv =====
// Testbench for the Laplacian variance and Sobel energy sharpness measure
`timescale 1ns / 1ps
module tb_laplacian_sobel_sharpness;
   import lss_pkg::*;

   class sharpness_scoreboard;
      bit [12:0] fw = RST_FRAME_WIDTH;
      bit [12:0] fh = RST_FRAME_HEIGHT;
      bit [6:0]  bw = RST_BORDER_WIDTH;
      bit [11:0] line_one [4096];
      bit [11:0] line_two [4096];
      int        win [6];
      int        col, row;
      bit [S1_W-1:0] lap_sum;
      bit [S2_W-1:0] lap_sq_sum;
      bit [G_W-1:0]  grad_sum;
      bit [N_W-1:0]  count;
      bit [RSP_DATA_W-1:0] frame_results [$];
      int frames_done;

      function void set_reg(bit [IDX_W-1:0] idx, bit [CFG_W-1:0] val);
         if (idx == REG_FRAME_WIDTH) fw = val;
         else if (idx == REG_FRAME_HEIGHT) fh = val;
         else if (idx == REG_BORDER_WIDTH) bw = val[6:0];
      endfunction

      function bit [RSP_DATA_W-1:0] frame_summary();
         bit [RSP_DATA_W-1:0] r;
         logic signed [S1_W-1:0] s39;
         longint sv, mq;
         bit [63:0] n, mag, fl, sq, var_q, sob;
         n = count;
         var_q = 0;
         sob = 0;
         if (n != 0) begin
            s39 = lap_sum;
            sv = s39;
            mq = (sv * 16) / longint'(n);
            mag = mq < 0 ? -mq : mq;
            fl = ({12'd0, lap_sq_sum} * 256) / n;
            if (mag <= 64'hFFFF_FFFF) begin
               sq = mag * mag;
               var_q = fl > sq ? fl - sq : 0;
               if (var_q > 64'hF_FFFF_FFFF) var_q = 64'hF_FFFF_FFFF;
            end
            sob = ({11'd0, grad_sum} * 256) / n;
            if (sob > 64'h1F_FFFF_FFFF) sob = 64'h1F_FFFF_FFFF;
         end
         r = '0;
         r[35:0] = var_q[35:0];
         r[72:36] = sob[36:0];
         r[97:73] = n[24:0];
         return r;
      endfunction

      function void note_pixel(bit [11:0] pix);
         int w, h, b, p, top, mid, lap, gx, gy, cx, cy;
         longint l2, g2;
         bit tiny;
         w = fw < 1 ? 1 : (fw > 4096 ? 4096 : fw);
         h = fh < 1 ? 1 : (fh > 4096 ? 4096 : fh);
         b = bw == 0 ? 1 : bw;
         p = pix;
         top = col < 4096 ? line_two[col] : 0;
         mid = col < 4096 ? line_one[col] : 0;
         tiny = (w <= 2 * b + 2) || (h <= 2 * b + 2);
         if (!tiny && col >= 1 && row >= 1) begin
            cx = col - 1;
            cy = row - 1;
            if (cx >= b && cx + b < w && cy >= b && cy + b < h) begin
               lap = win[1] + mid + win[3] + win[5] - 4 * win[4];
               gx = (top + 2 * mid + p) - (win[0] + 2 * win[1] + win[2]);
               gy = (win[2] + 2 * win[5] + p) - (win[0] + 2 * win[3] + top);
               l2 = longint'(lap) * lap;
               g2 = longint'(gx) * gx + longint'(gy) * gy;
               lap_sum = lap_sum + S1_W'(lap);
               lap_sq_sum = lap_sq_sum + S2_W'(l2);
               grad_sum = grad_sum + G_W'(g2);
               count = count + 1'b1;
            end
         end
         win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
         win[3] = top; win[4] = mid; win[5] = p;
         if (col < 4096) begin
            line_two[col] = mid;
            line_one[col] = pix;
         end
         if (col + 1 >= w) begin
            col = 0;
            if (row + 1 >= h) begin
               row = 0;
               frame_results.push_back(frame_summary());
               lap_sum = 0; lap_sq_sum = 0; grad_sum = 0; count = 0;
            end else
               row = row + 1;
         end else
            col = col + 1;
      endfunction

      function bit check_result(bit [RSP_DATA_W-1:0] got, output string why);
         bit [RSP_DATA_W-1:0] e;
         if (frame_results.size() == 0) begin
            why = "result with none pending";
            return 0;
         end
         e = frame_results.pop_front();
         frames_done++;
         why = "";
         if (got[35:0] != e[35:0])
            why = {why, $sformatf(" lap_variance %0d exp %0d", got[35:0], e[35:0])};
         if (got[72:36] != e[72:36])
            why = {why, $sformatf(" sobel_energy %0d exp %0d", got[72:36], e[72:36])};
         if (got[97:73] != e[97:73])
            why = {why, $sformatf(" measured_pixels %0d exp %0d", got[97:73], e[97:73])};
         return why == "";
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   sharpness_scoreboard sb = new();
   int errors = 0;
   int pixels_sent = 0;
   int stall_left = 0;
   bit calm = 0;
   int random_pixels;
   int w, h, b, mode;

   laplacian_sobel_sharpness uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic report(string msg);
      $display("mismatch @%0t:%s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      string why;
      if (!reset && req_tvalid && req_tready) sb.note_pixel(req_tdata[11:0]);
      if (!reset && rsp_tvalid && rsp_tready)
         if (!sb.check_result(rsp_tdata, why)) report(why);
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (calm) rsp_tready <= 1;
         else begin
            stall_left <= $urandom_range(0, 3);
            rsp_tready <= 0;
         end
      end else
         rsp_tready <= 1;
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, int val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val[CFG_W-1:0];
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_reg(idx, val[CFG_W-1:0]);
   endtask

   task automatic send_pixel(bit [11:0] pix);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'd0, pix};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      pixels_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.frame_results.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // pixel style: 0 random, 1 extremes, 2 checkerboard of extremes, 3 flat
   task automatic run_frame(int fw_v, int fh_v, int bw_v, int style);
      int wu, hu;
      bit [11:0] pix;
      write_reg(REG_FRAME_WIDTH, fw_v);
      write_reg(REG_FRAME_HEIGHT, fh_v);
      write_reg(REG_BORDER_WIDTH, bw_v);
      wu = fw_v < 1 ? 1 : (fw_v > 4096 ? 4096 : fw_v);
      hu = fh_v < 1 ? 1 : (fh_v > 4096 ? 4096 : fh_v);
      calm = ($urandom_range(0, 3) == 0);
      for (int y = 0; y < hu; y++)
         for (int x = 0; x < wu; x++) begin
            case (style)
               0: pix = $urandom_range(0, 4095);
               1: pix = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
               2: pix = ((x + y) % 2) ? 12'hFFF : 12'h000;
               default: pix = 12'hFFF;
            endcase
            send_pixel(pix);
         end
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      run_frame(5, 5, 1, 2);
      run_frame(5, 5, 0, 3);
      run_frame(6, 6, 2, 1);
      run_frame(7, 7, 2, 0);
      run_frame(1, 1, 1, 0);
      run_frame(0, 3, 1, 0);
      run_frame(4, 0, 1, 0);
      run_frame(1, 9, 127, 0);
      run_frame(16, 16, 6, 0);
      run_frame(14, 4, 6, 2);
      run_frame(3, 4, 1, 1);
      random_pixels = pixels_sent + 700;
      while (pixels_sent < random_pixels) begin
         mode = $urandom_range(0, 9);
         if (mode == 0) begin
            w = 1; h = $urandom_range(1, 3); b = $urandom_range(0, 2);
         end else begin
            w = $urandom_range(3, 12); h = $urandom_range(3, 12); b = $urandom_range(0, 3);
         end
         run_frame(w, h, b, mode < 6 ? 0 : (mode < 8 ? 1 : 2));
      end
      $display("covered %0d pixels in %0d frames, sizes 0 to 16, borders 0 to 127",
               pixels_sent, sb.frames_done);
      if (errors == 0 && sb.frame_results.size() == 0)
         $display("tb_laplacian_sobel_sharpness: done, clean");
      else
         $display("tb_laplacian_sobel_sharpness: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("tb_laplacian_sobel_sharpness: done, errors");
      $finish;
   end
endmodule
